/* sv/ctgm_pkg.sv */
// Package with the shared types, constants and helpers of the coarse template group matcher.
`timescale 1ns / 1ps
`default_nettype none
package ctgm_pkg;

  localparam int MAX_TEMPLATES = 64;
  localparam int COORD_BITS    = 12;
  localparam int LBL_W         = 8;
  localparam int IDX_W         = (MAX_TEMPLATES > 1) ? $clog2(MAX_TEMPLATES) : 1;
  localparam int FILL_W        = $clog2(MAX_TEMPLATES + 1);
  localparam int CNT_W         = $clog2(2 * MAX_TEMPLATES + 1);
  localparam int DIST_W        = 2 * COORD_BITS + 1;
  localparam int PROD_W        = 2 * DIST_W;
  localparam int SCL_W         = PROD_W + 7;
  localparam int DAT_W         = 2 * COORD_BITS + 2 * LBL_W;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [LBL_W-1:0]      label_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [FILL_W-1:0]     fill_t;
  typedef logic [DIST_W-1:0]     dist_t;

  typedef struct packed {
    logic       which_set;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [7:0] label_first;
    logic [7:0] label_second;
    logic       already_matched;
    logic       last_item;
  } ctgm_in_t;

  typedef struct packed {
    logic [7:0] match_count;
    logic       dropped;
  } ctgm_out_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    label_t la;
    label_t lb;
  } tmpl_t;

  typedef struct packed {
    idx_t   idx;
    coord_t x;
    coord_t y;
    dist_t  d;
  } member_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_QINIT, OP_QINC, OP_RINC, OP_QCENTER, OP_RCENTER, OP_DIST, OP_UPD,
    OP_QSAVE, OP_RSAVE, OP_QF1, OP_QF2, OP_RF1, OP_RF2, OP_QDIST, OP_RDIST,
    OP_CHECK, OP_MUL, OP_CMP, OP_MARK, OP_CINIT, OP_CADD, OP_FINISH
  } ctgm_op_t;

  typedef enum logic [1:0] {
    RSEL_OUTER, RSEL_SCAN, RSEL_G1, RSEL_G2
  } ctgm_rsel_t;

  typedef enum logic [4:0] {
    S_IDLE, S_Q_TEST, S_Q_CHK, S_SC_RD, S_SC_DST, S_SC_UPD, S_SC_END,
    S_QF1_RD, S_QF1_CAP, S_QF2_RD, S_QF2_CAP, S_QDIST,
    S_R_TEST, S_R_CHK, S_RF1_RD, S_RF1_CAP, S_RF2_RD, S_RF2_CAP, S_RDIST,
    S_CHECK, S_MUL, S_CMP, S_DECIDE, S_MARK, S_R_NEXT, S_Q_NEXT,
    S_CNT_RD, S_CNT_ADD, S_FIN
  } ctgm_state_t;

  typedef struct packed {
    ctgm_op_t   op;
    ctgm_rsel_t rsel;
  } ctgm_cmd_t;

  typedef struct packed {
    logic q_end;
    logic r_end;
    logic i_end;
    logic qflag;
    logic r_skip;
    logic have2;
    logic scan_ref;
    logic k_last;
    logic ok;
    logic cnt_end;
    logic out_free;
  } ctgm_status_t;

  // Squared Euclidean distance of two points.
  function automatic dist_t sq_dist(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    coord_t dx;
    coord_t dy;
    dx = (ax > bx) ? (ax - bx) : (bx - ax);
    dy = (ay > by) ? (ay - by) : (by - ay);
    return (dist_t'(dx) * dist_t'(dx)) + (dist_t'(dy) * dist_t'(dy));
  endfunction

endpackage
`default_nettype wire

/* sv/coarse_template_group_matcher.sv */
// Top level of the coarse template group matcher.
// Templates are loaded one per cycle while the block is idle: each transfer on the input
// channel stores one template into the query or reference store, up to 64 per set; further
// templates of a full set are dropped and reported through the dropped bit. The transfer
// that carries last_item starts the group matching pass, during which in_ready is low.
// The pass is run by a sequencer over stores with one write and one registered read port, so
// its length depends on the data: it builds the group of each unmatched query template, and
// for every same-label unmatched reference candidate it builds that candidate's group and
// runs the distance and ratio tests, followed by a flag count sweep over both sets. Exactly
// one result transfer follows each pass; a pending result does not block loading of the next
// sets. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none
module coarse_template_group_matcher (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ctgm_pkg::ctgm_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ctgm_pkg::ctgm_out_t out_data
);
  import ctgm_pkg::*;

  ctgm_cmd_t    cmd;
  ctgm_status_t status;
  logic         idle;
  logic         in_fire;

  // Inputs are taken only between passes.
  assign in_ready = idle;
  assign in_fire  = in_valid && idle;

  ctgm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_last(in_data.last_item),
    .status(status), .cmd(cmd), .idle(idle));

  ctgm_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_data(in_data), .cmd(cmd),
    .status(status), .out_ready(out_ready), .out_valid(out_valid), .out_data(out_data));
endmodule
`default_nettype wire

/* sv/ctgm_ram.sv */
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module ctgm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* sv/ctgm_datapath.sv */
// Datapath of the matcher: template stores, scan registers, distance and ratio units, counter.
`timescale 1ns / 1ps
`default_nettype none
module ctgm_datapath (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_fire,
  input  ctgm_pkg::ctgm_in_t     in_data,
  input  ctgm_pkg::ctgm_cmd_t    cmd,
  output ctgm_pkg::ctgm_status_t status,
  input  logic                   out_ready,
  output logic                   out_valid,
  output ctgm_pkg::ctgm_out_t    out_data
);
  import ctgm_pkg::*;

  fill_t   qfill_r, rfill_r, q_r, r_r, i_r;
  logic    ovf_r, out_valid_r;
  logic [CNT_W-1:0] cnt_r;
  logic [7:0] cnt_sat;
  tmpl_t   cur_r, qc_r, rc_r;
  idx_t    cidx_r, qcidx_r, rcidx_r;
  logic    scan_ref_r, have1_r, have2_r, elig_r;
  member_t g1_r, g2_r, cand_r, qg1_r, qg2_r, rg1_r, rg2_r;
  logic    qf1_r, qf2_r, rf1_r, rf2_r, ok_r;
  dist_t   dq_r [3];
  dist_t   dr_r [3];
  logic [1:0] k_r;
  logic [PROD_W-1:0] num_r, den_r;
  ctgm_out_t out_r;

  idx_t  qraddr, rraddr, qwaddr, rwaddr;
  logic  qdwe, rdwe, qfwe, rfwe, qfwd, rfwd;
  logic [DAT_W-1:0] wdat, qdrd, rdrd;
  logic  qflrd, rflrd;
  tmpl_t qrd, rrd, srd, new_t;
  coord_t ax, ay, bx, by;
  dist_t dist_u;
  dist_t qa, qb, ra, rb;
  logic [SCL_W-1:0] n100, d81, d121;
  logic [1:0] k_nxt;

  assign new_t = '{x: COORD_BITS'(in_data.pos_x), y: COORD_BITS'(in_data.pos_y),
                   la: in_data.label_first, lb: in_data.label_second};
  assign wdat  = new_t;
  assign qrd   = tmpl_t'(qdrd);
  assign rrd   = tmpl_t'(rdrd);
  assign srd   = scan_ref_r ? rrd : qrd;
  assign k_nxt = (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;

  // Read address selection, shared by the data and flag store of each set.
  always_comb begin
    unique case (cmd.rsel)
      RSEL_OUTER: begin qraddr = q_r[IDX_W-1:0]; rraddr = r_r[IDX_W-1:0]; end
      RSEL_SCAN:  begin qraddr = i_r[IDX_W-1:0]; rraddr = i_r[IDX_W-1:0]; end
      RSEL_G1:    begin qraddr = qg1_r.idx;      rraddr = rg1_r.idx;      end
      RSEL_G2:    begin qraddr = qg2_r.idx;      rraddr = rg2_r.idx;      end
      default:    begin qraddr = q_r[IDX_W-1:0]; rraddr = r_r[IDX_W-1:0]; end
    endcase
  end

  // Write ports: template loading, and marking of matched groups.
  always_comb begin
    qdwe = 1'b0; rdwe = 1'b0; qfwe = 1'b0; rfwe = 1'b0;
    qfwd = in_data.already_matched; rfwd = in_data.already_matched;
    qwaddr = qfill_r[IDX_W-1:0]; rwaddr = rfill_r[IDX_W-1:0];
    if (in_fire) begin
      if (!in_data.which_set && (qfill_r < fill_t'(MAX_TEMPLATES))) begin
        qdwe = 1'b1; qfwe = 1'b1;
      end
      if (in_data.which_set && (rfill_r < fill_t'(MAX_TEMPLATES))) begin
        rdwe = 1'b1; rfwe = 1'b1;
      end
    end else if (cmd.op == OP_MARK) begin
      qfwe = 1'b1; rfwe = 1'b1; qfwd = 1'b1; rfwd = 1'b1;
      case (k_r)
        2'd0:    begin qwaddr = qcidx_r;   rwaddr = rcidx_r;   end
        2'd1:    begin qwaddr = qg1_r.idx; rwaddr = rg1_r.idx; end
        default: begin qwaddr = qg2_r.idx; rwaddr = rg2_r.idx; end
      endcase
    end
  end

  ctgm_ram #(.WIDTH(DAT_W), .DEPTH(MAX_TEMPLATES)) u_qdat (
    .clk(clk), .we(qdwe), .waddr(qwaddr), .wdata(wdat), .raddr(qraddr), .rdata(qdrd));
  ctgm_ram #(.WIDTH(DAT_W), .DEPTH(MAX_TEMPLATES)) u_rdat (
    .clk(clk), .we(rdwe), .waddr(rwaddr), .wdata(wdat), .raddr(rraddr), .rdata(rdrd));
  ctgm_ram #(.WIDTH(1), .DEPTH(MAX_TEMPLATES)) u_qflg (
    .clk(clk), .we(qfwe), .waddr(qwaddr), .wdata(qfwd), .raddr(qraddr), .rdata(qflrd));
  ctgm_ram #(.WIDTH(1), .DEPTH(MAX_TEMPLATES)) u_rflg (
    .clk(clk), .we(rfwe), .waddr(rwaddr), .wdata(rfwd), .raddr(rraddr), .rdata(rflrd));

  // One shared distance unit.
  always_comb begin
    ax = cur_r.x; ay = cur_r.y; bx = srd.x; by = srd.y;
    case (cmd.op)
      OP_QDIST: begin
        case (k_r)
          2'd0:    begin ax = qc_r.x;  ay = qc_r.y;  bx = qg1_r.x; by = qg1_r.y; end
          2'd1:    begin ax = qc_r.x;  ay = qc_r.y;  bx = qg2_r.x; by = qg2_r.y; end
          default: begin ax = qg1_r.x; ay = qg1_r.y; bx = qg2_r.x; by = qg2_r.y; end
        endcase
      end
      OP_RDIST: begin
        case (k_r)
          2'd0:    begin ax = rc_r.x;  ay = rc_r.y;  bx = rg1_r.x; by = rg1_r.y; end
          2'd1:    begin ax = rc_r.x;  ay = rc_r.y;  bx = rg2_r.x; by = rg2_r.y; end
          default: begin ax = rg1_r.x; ay = rg1_r.y; bx = rg2_r.x; by = rg2_r.y; end
        endcase
      end
      default: ;
    endcase
    dist_u = sq_dist(ax, ay, bx, by);
  end

  // Operands of the ratio test selected by the ratio counter.
  always_comb begin
    case (k_r)
      2'd0:    begin qa = dq_r[0]; qb = dq_r[1]; ra = dr_r[0]; rb = dr_r[1]; end
      2'd1:    begin qa = dq_r[0]; qb = dq_r[2]; ra = dr_r[0]; rb = dr_r[2]; end
      default: begin qa = dq_r[1]; qb = dq_r[2]; ra = dr_r[1]; rb = dr_r[2]; end
    endcase
  end

  assign n100 = SCL_W'(num_r) * SCL_W'(100);
  assign d81  = SCL_W'(den_r) * SCL_W'(81);
  assign d121 = SCL_W'(den_r) * SCL_W'(121);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qfill_r     <= '0;
      rfill_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        if (!in_data.which_set) begin
          if (qfill_r < fill_t'(MAX_TEMPLATES)) qfill_r <= qfill_r + fill_t'(1);
          else ovf_r <= 1'b1;
        end else begin
          if (rfill_r < fill_t'(MAX_TEMPLATES)) rfill_r <= rfill_r + fill_t'(1);
          else ovf_r <= 1'b1;
        end
      end
      if (cmd.op == OP_FINISH) begin
        qfill_r     <= '0;
        rfill_r     <= '0;
        ovf_r       <= 1'b0;
        out_valid_r <= 1'b1;
        out_r       <= '{match_count: cnt_sat, dropped: ovf_r};
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (cmd.op)
        OP_QINIT: q_r <= '0;
        OP_QINC:  q_r <= q_r + fill_t'(1);
        OP_RINC:  r_r <= r_r + fill_t'(1);
        OP_QCENTER: begin
          cur_r <= qrd; cidx_r <= q_r[IDX_W-1:0]; scan_ref_r <= 1'b0;
          have1_r <= 1'b0; have2_r <= 1'b0; i_r <= '0;
        end
        OP_RCENTER: begin
          cur_r <= rrd; cidx_r <= r_r[IDX_W-1:0]; scan_ref_r <= 1'b1;
          have1_r <= 1'b0; have2_r <= 1'b0; i_r <= '0;
        end
        OP_DIST: begin
          elig_r <= (i_r[IDX_W-1:0] != cidx_r) && (srd.la == cur_r.la) &&
                    (srd.lb == cur_r.lb);
          cand_r <= '{idx: i_r[IDX_W-1:0], x: srd.x, y: srd.y, d: dist_u};
        end
        OP_UPD: begin
          // Nearest two neighbors; ties keep the earlier index.
          if (elig_r) begin
            if (!have1_r) begin
              have1_r <= 1'b1; g1_r <= cand_r;
            end else if (cand_r.d < g1_r.d) begin
              have2_r <= 1'b1; g2_r <= g1_r; g1_r <= cand_r;
            end else if (!have2_r) begin
              have2_r <= 1'b1; g2_r <= cand_r;
            end else if (cand_r.d < g2_r.d) begin
              g2_r <= cand_r;
            end
          end
          i_r <= i_r + fill_t'(1);
        end
        OP_QSAVE: begin
          qc_r <= cur_r; qcidx_r <= cidx_r; qg1_r <= g1_r; qg2_r <= g2_r;
          k_r <= 2'd0; r_r <= '0;
        end
        OP_RSAVE: begin
          rc_r <= cur_r; rcidx_r <= cidx_r; rg1_r <= g1_r; rg2_r <= g2_r;
          k_r <= 2'd0;
        end
        OP_QF1: qf1_r <= qflrd;
        OP_QF2: qf2_r <= qflrd;
        OP_RF1: rf1_r <= rflrd;
        OP_RF2: rf2_r <= rflrd;
        OP_QDIST: begin dq_r[k_r] <= dist_u; k_r <= k_nxt; end
        OP_RDIST: begin dr_r[k_r] <= dist_u; k_r <= k_nxt; end
        OP_CHECK: begin
          ok_r <= (qf1_r == rf1_r) && (qf2_r == rf2_r) &&
                  (dq_r[0] != '0) && (dq_r[1] != '0) && (dq_r[2] != '0) &&
                  (dr_r[0] != '0) && (dr_r[1] != '0) && (dr_r[2] != '0);
        end
        OP_MUL: begin
          num_r <= PROD_W'(qa) * PROD_W'(rb);
          den_r <= PROD_W'(qb) * PROD_W'(ra);
        end
        OP_CMP: begin
          ok_r <= ok_r && (d81 < n100) && (n100 < d121);
          k_r  <= k_nxt;
        end
        OP_MARK: k_r <= k_nxt;
        OP_CINIT: begin i_r <= '0; cnt_r <= '0; end
        OP_CADD: begin
          cnt_r <= cnt_r + CNT_W'((i_r < qfill_r) && qflrd) +
                   CNT_W'((i_r < rfill_r) && rflrd);
          i_r <= i_r + fill_t'(1);
        end
        default: ;
      endcase
    end
  end

  assign cnt_sat = (32'(cnt_r) > 32'd255) ? 8'hFF : 8'(cnt_r);

  always_comb begin
    status.q_end    = (q_r >= qfill_r);
    status.r_end    = (r_r >= rfill_r);
    status.i_end    = (i_r >= (scan_ref_r ? rfill_r : qfill_r));
    status.qflag    = qflrd;
    status.r_skip   = rflrd || (rrd.la != qc_r.la) || (rrd.lb != qc_r.lb);
    status.have2    = have2_r;
    status.scan_ref = scan_ref_r;
    status.k_last   = (k_r == 2'd2);
    status.ok       = ok_r;
    status.cnt_end  = (i_r >= qfill_r) && (i_r >= rfill_r);
    status.out_free = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire

/* sv/ctgm_ctrl.sv */
// Controller state machine that sequences loading, the group matching pass and the count.
`timescale 1ns / 1ps
`default_nettype none
module ctgm_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_fire,
  input  logic                   in_last,
  input  ctgm_pkg::ctgm_status_t status,
  output ctgm_pkg::ctgm_cmd_t    cmd,
  output logic                   idle
);
  import ctgm_pkg::*;

  ctgm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_fire && in_last) state_nxt = S_Q_TEST;
      S_Q_TEST:  state_nxt = status.q_end ? S_CNT_RD : S_Q_CHK;
      S_Q_CHK:   state_nxt = status.qflag ? S_Q_NEXT : S_SC_RD;
      S_SC_RD:   state_nxt = status.i_end ? S_SC_END : S_SC_DST;
      S_SC_DST:  state_nxt = S_SC_UPD;
      S_SC_UPD:  state_nxt = S_SC_RD;
      S_SC_END: begin
        if (!status.have2) state_nxt = status.scan_ref ? S_R_NEXT : S_Q_NEXT;
        else               state_nxt = status.scan_ref ? S_RF1_RD : S_QF1_RD;
      end
      S_QF1_RD:  state_nxt = S_QF1_CAP;
      S_QF1_CAP: state_nxt = S_QF2_RD;
      S_QF2_RD:  state_nxt = S_QF2_CAP;
      S_QF2_CAP: state_nxt = S_QDIST;
      S_QDIST:   if (status.k_last) state_nxt = S_R_TEST;
      S_R_TEST:  state_nxt = status.r_end ? S_Q_NEXT : S_R_CHK;
      S_R_CHK:   state_nxt = status.r_skip ? S_R_NEXT : S_SC_RD;
      S_RF1_RD:  state_nxt = S_RF1_CAP;
      S_RF1_CAP: state_nxt = S_RF2_RD;
      S_RF2_RD:  state_nxt = S_RF2_CAP;
      S_RF2_CAP: state_nxt = S_RDIST;
      S_RDIST:   if (status.k_last) state_nxt = S_CHECK;
      S_CHECK:   state_nxt = S_MUL;
      S_MUL:     state_nxt = S_CMP;
      S_CMP:     state_nxt = status.k_last ? S_DECIDE : S_MUL;
      S_DECIDE:  state_nxt = status.ok ? S_MARK : S_R_NEXT;
      S_MARK:    if (status.k_last) state_nxt = S_Q_NEXT;
      S_R_NEXT:  state_nxt = S_R_TEST;
      S_Q_NEXT:  state_nxt = S_Q_TEST;
      S_CNT_RD:  state_nxt = status.cnt_end ? S_FIN : S_CNT_ADD;
      S_CNT_ADD: state_nxt = S_CNT_RD;
      S_FIN:     if (status.out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = OP_NONE;
    cmd.rsel = RSEL_OUTER;
    unique case (state_r)
      S_IDLE:    cmd.op = OP_QINIT;
      S_Q_TEST:  if (status.q_end) cmd.op = OP_CINIT;
      S_Q_CHK:   if (!status.qflag) cmd.op = OP_QCENTER;
      S_SC_RD:   cmd.rsel = RSEL_SCAN;
      S_SC_DST:  begin cmd.op = OP_DIST; cmd.rsel = RSEL_SCAN; end
      S_SC_UPD:  cmd.op = OP_UPD;
      S_SC_END:  if (status.have2) cmd.op = status.scan_ref ? OP_RSAVE : OP_QSAVE;
      S_QF1_RD:  cmd.rsel = RSEL_G1;
      S_QF1_CAP: cmd.op = OP_QF1;
      S_QF2_RD:  cmd.rsel = RSEL_G2;
      S_QF2_CAP: cmd.op = OP_QF2;
      S_QDIST:   cmd.op = OP_QDIST;
      S_R_TEST:  cmd.rsel = RSEL_OUTER;
      S_R_CHK:   if (!status.r_skip) cmd.op = OP_RCENTER;
      S_RF1_RD:  cmd.rsel = RSEL_G1;
      S_RF1_CAP: cmd.op = OP_RF1;
      S_RF2_RD:  cmd.rsel = RSEL_G2;
      S_RF2_CAP: cmd.op = OP_RF2;
      S_RDIST:   cmd.op = OP_RDIST;
      S_CHECK:   cmd.op = OP_CHECK;
      S_MUL:     cmd.op = OP_MUL;
      S_CMP:     cmd.op = OP_CMP;
      S_DECIDE:  ;
      S_MARK:    cmd.op = OP_MARK;
      S_R_NEXT:  cmd.op = OP_RINC;
      S_Q_NEXT:  cmd.op = OP_QINC;
      S_CNT_RD:  cmd.rsel = RSEL_SCAN;
      S_CNT_ADD: begin cmd.op = OP_CADD; cmd.rsel = RSEL_SCAN; end
      S_FIN:     if (status.out_free) cmd.op = OP_FINISH;
      default:   ;
    endcase
  end

  assign idle = (state_r == S_IDLE);
endmodule
`default_nettype wire

/* sv/ctgm_checker.sv */
// Port-level checker of the coarse template group matcher and its bind.
`timescale 1ns / 1ps
`default_nettype none
module ctgm_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input ctgm_pkg::ctgm_in_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input ctgm_pkg::ctgm_out_t out_data
);
  import ctgm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data)) else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result shown after reset");

  a_pass_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_item |=> !in_ready)
    else $error("input taken while the matching pass runs");
endmodule

bind coarse_template_group_matcher ctgm_checker u_ctgm_checker (.*);
`default_nettype wire

/* tb/tb_coarse_template_group_matcher.sv */
// Self-checking testbench for the coarse template group matcher.
`timescale 1ns / 1ps
module tb_coarse_template_group_matcher;
  import ctgm_pkg::*;

  // Longest run of cycles without any transfer before the run is declared hung.
  // It lies well above the slowest pass in this stimulus and the receiver hold-off.
  localparam int IDLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 3000;
  localparam int ITEM_GOAL = 1600;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  ctgm_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  ctgm_out_t out_data;

  coarse_template_group_matcher DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Shadow copy of both template stores. Index 0 is the query set, 1 the reference set.
  typedef struct {
    logic [11:0] x;
    logic [11:0] y;
    logic [7:0]  la;
    logic [7:0]  lb;
    bit          flag;
  } shadow_tmpl_t;

  shadow_tmpl_t sets[2][MAX_TEMPLATES];
  int unsigned  set_fill[2];
  bit           overflow_hit;

  ctgm_out_t expected_counts[$];
  int        fail_cnt;
  int        mismatch_cnt;
  int        items_sent;
  bit        hold_req;
  int        burst_left;

  // Directed table: each row is one input transfer; rows with a typed result carry it.
  typedef struct {
    ctgm_in_t  d;
    bit        typed;
    ctgm_out_t e;
  } dir_row_t;
  dir_row_t dir_rows[$];

  function automatic longint unsigned tmpl_dist(int s, int a, int b);
    longint unsigned dx;
    longint unsigned dy;
    dx = (sets[s][a].x > sets[s][b].x) ? sets[s][a].x - sets[s][b].x
                                       : sets[s][b].x - sets[s][a].x;
    dy = (sets[s][a].y > sets[s][b].y) ? sets[s][a].y - sets[s][b].y
                                       : sets[s][b].y - sets[s][a].y;
    return dx * dx + dy * dy;
  endfunction

  // Two nearest same-label neighbors of template c; earlier index wins a tie.
  function automatic bit nearest_pair(int s, int c, output int g1, output int g2);
    bit              have1;
    bit              have2;
    longint unsigned d;
    longint unsigned d1;
    longint unsigned d2;
    have1 = 0;
    have2 = 0;
    d1 = 0;
    d2 = 0;
    g1 = 0;
    g2 = 0;
    for (int i = 0; i < set_fill[s]; i++) begin
      if (i == c || sets[s][i].la != sets[s][c].la || sets[s][i].lb != sets[s][c].lb) continue;
      d = tmpl_dist(s, c, i);
      if (!have1) begin
        have1 = 1; g1 = i; d1 = d;
      end else if (d < d1) begin
        have2 = 1; g2 = g1; d2 = d1; g1 = i; d1 = d;
      end else if (!have2) begin
        have2 = 1; g2 = i; d2 = d;
      end else if (d < d2) begin
        g2 = i; d2 = d;
      end
    end
    return have1 && have2;
  endfunction

  // Ratio of squared ratios strictly inside (0.81, 1.21), evaluated exactly.
  function automatic bit ratios_agree(longint unsigned qa, longint unsigned qb,
                                      longint unsigned ra, longint unsigned rb);
    logic [127:0] num;
    logic [127:0] den;
    num = 128'(qa) * 128'(rb) * 128'd100;
    den = 128'(qb) * 128'(ra);
    return (den * 128'd81 < num) && (num < den * 128'd121);
  endfunction

  function automatic bit groups_agree(int qg[3], int rg[3]);
    longint unsigned q1, q2, q3, r1, r2, r3;
    for (int k = 0; k < 3; k++)
      if (sets[0][qg[k]].flag != sets[1][rg[k]].flag) return 0;
    q1 = tmpl_dist(0, qg[0], qg[1]);
    q2 = tmpl_dist(0, qg[0], qg[2]);
    q3 = tmpl_dist(0, qg[1], qg[2]);
    r1 = tmpl_dist(1, rg[0], rg[1]);
    r2 = tmpl_dist(1, rg[0], rg[2]);
    r3 = tmpl_dist(1, rg[1], rg[2]);
    // Any zero distance inside either group rules the match out.
    if (q1 == 0 || q2 == 0 || q3 == 0 || r1 == 0 || r2 == 0 || r3 == 0) return 0;
    return ratios_agree(q1, q2, r1, r2) && ratios_agree(q1, q3, r1, r3) &&
           ratios_agree(q2, q3, r2, r3);
  endfunction

  function automatic int marked_after_matching();
    int qg[3];
    int rg[3];
    int cnt;
    for (int q = 0; q < set_fill[0]; q++) begin
      if (sets[0][q].flag) continue;
      qg[0] = q;
      if (!nearest_pair(0, q, qg[1], qg[2])) continue;
      for (int r = 0; r < set_fill[1]; r++) begin
        if (sets[1][r].flag || sets[1][r].la != sets[0][q].la ||
            sets[1][r].lb != sets[0][q].lb) continue;
        rg[0] = r;
        if (!nearest_pair(1, r, rg[1], rg[2])) continue;
        if (groups_agree(qg, rg)) begin
          for (int k = 0; k < 3; k++) begin
            sets[0][qg[k]].flag = 1;
            sets[1][rg[k]].flag = 1;
          end
          break;
        end
      end
    end
    cnt = 0;
    for (int s = 0; s < 2; s++)
      for (int i = 0; i < set_fill[s]; i++) cnt += sets[s][i].flag;
    return (cnt > 255) ? 255 : cnt;
  endfunction

  // Applies one accepted template to the shadow stores; on the last item it queues
  // the predicted count, or the typed value when the directed row gives one.
  function automatic void load_template(ctgm_in_t t, bit typed, ctgm_out_t typed_res);
    int        s;
    ctgm_out_t res;
    s = t.which_set;
    if (set_fill[s] < MAX_TEMPLATES) begin
      sets[s][set_fill[s]].x    = t.pos_x;
      sets[s][set_fill[s]].y    = t.pos_y;
      sets[s][set_fill[s]].la   = t.label_first;
      sets[s][set_fill[s]].lb   = t.label_second;
      sets[s][set_fill[s]].flag = t.already_matched;
      set_fill[s]++;
    end else begin
      overflow_hit = 1;
    end
    if (!t.last_item) return;
    res.match_count = 8'(marked_after_matching());
    res.dropped = overflow_hit;
    expected_counts = {expected_counts, (typed ? typed_res : res)};
    set_fill[0] = 0;
    set_fill[1] = 0;
    overflow_hit = 0;
  endfunction

  function automatic ctgm_in_t mk(bit ws, int x, int y, int la, int lb, bit f, bit l);
    ctgm_in_t t;
    t.which_set       = ws;
    t.pos_x           = 12'(x);
    t.pos_y           = 12'(y);
    t.label_first     = 8'(la);
    t.label_second    = 8'(lb);
    t.already_matched = f;
    t.last_item       = l;
    return t;
  endfunction

  // Sender: bursts of random length separated by random gaps. Valid stays high
  // across back-to-back transfers inside a burst.
  task automatic send_template(ctgm_in_t t, bit typed, ctgm_out_t typed_res);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (!in_ready);
    load_template(t, typed, typed_res);
    items_sent++;
  endtask

  task automatic add_row(ctgm_in_t d, bit typed, int cnt, bit drp);
    dir_row_t r;
    r.d = d;
    r.typed = typed;
    r.e.match_count = 8'(cnt);
    r.e.dropped = drp;
    dir_rows = {dir_rows, r};
  endtask

  // One random pass. Most passes hold a query group and a translated or scaled copy
  // in the reference set, so the ratio test is really exercised; a few overflow a store.
  task automatic random_pass();
    ctgm_in_t  items[$];
    ctgm_out_t none;
    int        la, lb, qbx, qby, rbx, rby, scl, n_noise;
    int        ox[3];
    int        oy[3];
    none = '0;
    if ($urandom_range(0, 24) == 0) begin
      // Overflow: distinct labels keep the pass short.
      for (int i = 0; i < MAX_TEMPLATES + $urandom_range(1, 4); i++)
        items = {items, mk(0, $urandom_range(0, 4095), $urandom_range(0, 4095), i,
                           $urandom_range(0, 255), $urandom_range(0, 1), 0)};
      for (int i = 0; i < $urandom_range(1, 3); i++)
        items = {items, mk(1, $urandom_range(0, 4095), $urandom_range(0, 4095),
                           $urandom_range(0, 255), $urandom_range(0, 255), 0, 0)};
    end else begin
      la = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 3);
      lb = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 3);
      qbx = $urandom_range(0, 3000);
      qby = $urandom_range(0, 3000);
      rbx = $urandom_range(0, 3000);
      rby = $urandom_range(0, 3000);
      scl = $urandom_range(1, 3);
      for (int k = 0; k < 3; k++) begin
        ox[k] = $urandom_range(0, 300);
        oy[k] = $urandom_range(0, 300);
      end
      for (int k = 0; k < 3; k++)
        items = {items, mk(0, qbx + ox[k], qby + oy[k], la, lb, $urandom_range(0, 7) == 0, 0)};
      for (int k = 0; k < 3; k++)
        items = {items, mk(1, rbx + scl * ox[k] + $urandom_range(0, 12),
                           rby + scl * oy[k] + $urandom_range(0, 12), la, lb,
                           $urandom_range(0, 7) == 0, 0)};
      n_noise = $urandom_range(0, 6);
      for (int i = 0; i < n_noise; i++)
        items = {items, mk($urandom_range(0, 1), $urandom_range(0, 4095), $urandom_range(0, 4095),
                           $urandom_range(0, 1) ? la : $urandom_range(0, 255),
                           $urandom_range(0, 1) ? lb : $urandom_range(0, 255),
                           $urandom_range(0, 1), 0)};
      items.shuffle();
    end
    items[items.size() - 1].last_item = 1'b1;
    foreach (items[i]) send_template(items[i], 0, none);
  endtask

  // Receiver: checks each result transfer against the oldest prediction, and stalls
  // on its own random pattern or for a long hold-off when asked.
  initial begin
    ctgm_out_t want;
    int        hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_counts.size() == 0) begin
          fail_cnt++;
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected result transfer: count %0d dropped %0b",
                     out_data.match_count, out_data.dropped);
        end else begin
          want = expected_counts.pop_front();
          if (out_data.match_count !== want.match_count || out_data.dropped !== want.dropped) begin
            fail_cnt++;
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("result mismatch: expected count %0d dropped %0b, got count %0d dropped %0b",
                       want.match_count, want.dropped, out_data.match_count, out_data.dropped);
          end
        end
      end
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("tb_coarse_template_group_matcher: FAIL");
        $finish;
      end
    end
  end

  initial begin
    ctgm_out_t none;
    int        passes;
    none = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    fail_cnt = 0;
    mismatch_cnt = 0;
    items_sent = 0;
    hold_req = 0;
    burst_left = 0;
    set_fill[0] = 0;
    set_fill[1] = 0;
    overflow_hit = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Lone templates: counts follow directly from the initial flags.
    add_row(mk(0, 0, 0, 0, 0, 0, 1), 1, 0, 0);
    add_row(mk(0, 4095, 0, 255, 0, 1, 1), 1, 1, 0);
    add_row(mk(1, 4095, 4095, 255, 255, 1, 1), 1, 1, 0);
    add_row(mk(0, 0, 4095, 0, 255, 1, 0), 0, 0, 0);
    add_row(mk(1, 4095, 0, 255, 0, 1, 1), 1, 2, 0);
    // Exact copy of a triangle in the reference set: a clean match.
    add_row(mk(0, 0, 0, 5, 7, 0, 0), 0, 0, 0);
    add_row(mk(0, 100, 0, 5, 7, 0, 0), 0, 0, 0);
    add_row(mk(0, 0, 200, 5, 7, 0, 0), 0, 0, 0);
    add_row(mk(1, 3995, 3895, 5, 7, 0, 0), 0, 0, 0);
    add_row(mk(1, 4095, 3895, 5, 7, 0, 0), 0, 0, 0);
    add_row(mk(1, 3995, 4095, 5, 7, 0, 1), 0, 0, 0);
    // Coincident points: zero distance must block the match.
    add_row(mk(0, 10, 10, 9, 9, 0, 0), 0, 0, 0);
    add_row(mk(0, 10, 10, 9, 9, 0, 0), 0, 0, 0);
    add_row(mk(0, 50, 50, 9, 9, 0, 0), 0, 0, 0);
    add_row(mk(1, 20, 20, 9, 9, 0, 0), 0, 0, 0);
    add_row(mk(1, 20, 20, 9, 9, 0, 0), 0, 0, 0);
    add_row(mk(1, 60, 60, 9, 9, 0, 1), 0, 0, 0);
    // Square corners: equal distances exercise the nearest-neighbor tie rule,
    // and a matched neighbor only enters through the flag test.
    add_row(mk(0, 0, 0, 3, 3, 0, 0), 0, 0, 0);
    add_row(mk(0, 10, 0, 3, 3, 0, 0), 0, 0, 0);
    add_row(mk(0, 0, 10, 3, 3, 0, 0), 0, 0, 0);
    add_row(mk(0, 10, 10, 3, 3, 1, 0), 0, 0, 0);
    add_row(mk(1, 500, 500, 3, 3, 0, 0), 0, 0, 0);
    add_row(mk(1, 510, 500, 3, 3, 0, 0), 0, 0, 0);
    add_row(mk(1, 500, 510, 3, 3, 0, 0), 0, 0, 0);
    add_row(mk(1, 510, 510, 3, 3, 1, 1), 0, 0, 0);
    foreach (dir_rows[i]) send_template(dir_rows[i].d, dir_rows[i].typed, dir_rows[i].e);

    passes = 0;
    while (items_sent < ITEM_GOAL) begin
      // Long receiver hold-off while the sender keeps offering, so the block backs up.
      if (passes == 10) hold_req = 1;
      // Sender pause until the block has drained completely.
      if (passes == 40 || passes == 90) begin
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (expected_counts.size() != 0);
      end
      random_pass();
      passes++;
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (expected_counts.size() != 0);
    repeat (100) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tb_coarse_template_group_matcher: PASS");
    end else begin
      $display("tb_coarse_template_group_matcher: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/ctgm_pkg.sv
sv/ctgm_ram.sv
sv/ctgm_datapath.sv
sv/ctgm_ctrl.sv
sv/coarse_template_group_matcher.sv
sv/ctgm_checker.sv
tb/tb_coarse_template_group_matcher.sv
